/* rtl/core/mrb_pkg.sv */
package mrb_pkg;

    localparam int TDATA_IN_W  = 88;
    localparam int TDATA_OUT_W = 32;
    localparam int TUSER_OUT_W = 2;

    localparam int VOICE_W = 2;
    localparam int MODE_W  = 4;
    localparam int EXC_W   = 24;
    localparam int COEF_W  = 18;
    localparam int GAIN_W  = 20;
    localparam int STATE_W = 32;
    localparam int MIX_W   = 32;

    localparam int VOICE_LSB = 0;
    localparam int MODE_LSB  = VOICE_LSB + VOICE_W;
    localparam int EXC_LSB   = MODE_LSB + MODE_W;
    localparam int COS_LSB   = EXC_LSB + EXC_W;
    localparam int SIN_LSB   = COS_LSB + COEF_W;
    localparam int GAIN_LSB  = SIN_LSB + COEF_W;

    localparam int COEF_WORD_W  = 2 * COEF_W + GAIN_W;
    localparam int STATE_WORD_W = 2 * STATE_W;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                      is_coef;
        logic [VOICE_W-1:0]        voice;
        logic [MODE_W-1:0]         mode;
        logic signed [EXC_W-1:0]   excitation;
        logic signed [COEF_W-1:0]  pole_cos;
        logic signed [COEF_W-1:0]  pole_sin;
        logic signed [GAIN_W-1:0]  mode_gain;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t item;
    } push_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } back_state_t;

endpackage

/* rtl/core/mrb_ram.sv */
module mrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/mrb_front.sv */
module mrb_front #(
    parameter int VOICES = 4,
    parameter int MODES  = 16
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mrb_pkg::TDATA_IN_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            q_full,
    output mrb_pkg::push_t                  push
);

    mrb_pkg::item_t item;
    logic           keep;

    always_comb
    begin
        item.is_coef    = (s_tuser == mrb_pkg::CMD_COEF);
        item.voice      = s_tdata[mrb_pkg::VOICE_LSB +: mrb_pkg::VOICE_W];
        item.mode       = s_tdata[mrb_pkg::MODE_LSB +: mrb_pkg::MODE_W];
        item.excitation = s_tdata[mrb_pkg::EXC_LSB +: mrb_pkg::EXC_W];
        item.pole_cos   = s_tdata[mrb_pkg::COS_LSB +: mrb_pkg::COEF_W];
        item.pole_sin   = s_tdata[mrb_pkg::SIN_LSB +: mrb_pkg::COEF_W];
        item.mode_gain  = s_tdata[mrb_pkg::GAIN_LSB +: mrb_pkg::GAIN_W];
    end

    // drop writes to absent modes and samples for absent voices
    assign keep = item.is_coef ? (int'(item.mode) < MODES) : (int'(item.voice) < VOICES);

    assign s_tready  = !q_full;
    assign push.push = s_tvalid && s_tready && keep;
    assign push.item = item;

endmodule

/* rtl/core/mrb_queue.sv */
module mrb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  mrb_pkg::push_t  push,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output mrb_pkg::item_t  head
);

    mrb_pkg::item_t              mem_reg [mrb_pkg::QUEUE_DEPTH];
    logic [mrb_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [mrb_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [mrb_pkg::QCNT_W-1:0]  count_reg;
    logic [mrb_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [mrb_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [mrb_pkg::QCNT_W-1:0]  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (count_reg == mrb_pkg::QCNT_W'(mrb_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push.push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mrb_pkg::QPTR_W'(mrb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mrb_pkg::QPTR_W'(mrb_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

/* rtl/core/mrb_back.sv */
module mrb_back #(
    parameter int VOICES = 4,
    parameter int MODES  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  mrb_pkg::item_t                   head,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrb_pkg::TDATA_OUT_W-1:0]  m_tdata,
    output logic [mrb_pkg::TUSER_OUT_W-1:0]  m_tuser
);

    localparam int TOTAL   = VOICES * MODES;
    localparam int RES_AW  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int MODE_AW = (MODES > 1) ? $clog2(MODES) : 1;
    localparam int ACC_W   = mrb_pkg::STATE_W + MODE_AW + 1;
    localparam int PX_W    = mrb_pkg::COEF_W + mrb_pkg::STATE_W;
    localparam int PG_W    = mrb_pkg::GAIN_W + mrb_pkg::EXC_W;
    localparam int SUM_W   = PX_W + 2;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(32768);

    function automatic logic signed [mrb_pkg::STATE_W-1:0] rnd_sat(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] sh;
        logic signed [mrb_pkg::STATE_W-1:0] r;
        sh = (v + HALF) >>> 16;
        if (sh > SUM_MAX)
        begin
            r = SUM_MAX[mrb_pkg::STATE_W-1:0];
        end
        else if (sh < SUM_MIN)
        begin
            r = SUM_MIN[mrb_pkg::STATE_W-1:0];
        end
        else
        begin
            r = sh[mrb_pkg::STATE_W-1:0];
        end
        return r;
    endfunction

    mrb_pkg::back_state_t state_reg;
    mrb_pkg::back_state_t state_next;

    logic                  coef_we;
    logic                  start;
    logic                  issue;
    logic                  clr_we;
    logic                  load_out;

    logic [RES_AW-1:0]     clr_reg;
    logic [RES_AW-1:0]     idx_reg;
    logic [MODE_AW-1:0]    m_reg;
    logic [mrb_pkg::VOICE_W-1:0]      voice_reg;
    logic signed [mrb_pkg::EXC_W-1:0] smp_reg;
    logic signed [ACC_W-1:0]          acc_reg;

    logic                  v1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;
    logic [RES_AW-1:0]     a1_reg;
    logic [RES_AW-1:0]     a2_reg;
    logic [RES_AW-1:0]     a3_reg;
    logic [RES_AW-1:0]     a4_reg;

    logic signed [PX_W-1:0]  cx_reg;
    logic signed [PX_W-1:0]  sy_reg;
    logic signed [PX_W-1:0]  sx_reg;
    logic signed [PX_W-1:0]  cy_reg;
    logic signed [PG_W-1:0]  gs_reg;
    logic signed [SUM_W-1:0] sumx_reg;
    logic signed [SUM_W-1:0] sumy_reg;
    logic signed [mrb_pkg::STATE_W-1:0] nx_reg;
    logic signed [mrb_pkg::STATE_W-1:0] ny_reg;

    logic                                out_valid_reg;
    logic [mrb_pkg::VOICE_W-1:0]         out_voice_reg;
    logic [mrb_pkg::MIX_W-1:0]           out_mix_reg;

    logic [mrb_pkg::STATE_WORD_W-1:0]    st_rdata;
    logic [mrb_pkg::STATE_WORD_W-1:0]    st_wdata;
    logic [RES_AW-1:0]                   st_waddr;
    logic                                st_we;
    logic [mrb_pkg::COEF_WORD_W-1:0]     cf_rdata;
    logic [mrb_pkg::COEF_WORD_W-1:0]     cf_wdata;
    logic [MODE_AW+mrb_pkg::MODE_W-1:0]  mode_ext;
    logic [RES_AW-1:0]                   base;

    logic signed [mrb_pkg::STATE_W-1:0]  rx;
    logic signed [mrb_pkg::STATE_W-1:0]  ry;
    logic signed [mrb_pkg::COEF_W-1:0]   rc;
    logic signed [mrb_pkg::COEF_W-1:0]   rs;
    logic signed [mrb_pkg::GAIN_W-1:0]   rg;
    logic pipe_busy;

    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrb_pkg::ST_CLEAR:
            begin
                if (clr_reg == RES_AW'(TOTAL - 1))
                begin
                    state_next = mrb_pkg::ST_IDLE;
                end
            end
            mrb_pkg::ST_IDLE:
            begin
                if (!q_empty && !head.is_coef)
                begin
                    state_next = mrb_pkg::ST_RUN;
                end
            end
            mrb_pkg::ST_RUN:
            begin
                if (m_reg == MODE_AW'(MODES - 1))
                begin
                    state_next = mrb_pkg::ST_DRAIN;
                end
            end
            mrb_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = mrb_pkg::ST_FINISH;
                end
            end
            mrb_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = mrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        issue    = 1'b0;
        clr_we   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            mrb_pkg::ST_CLEAR:  clr_we   = 1'b1;
            mrb_pkg::ST_IDLE:   pop      = !q_empty;
            mrb_pkg::ST_RUN:    issue    = 1'b1;
            mrb_pkg::ST_FINISH: load_out = !out_valid_reg || m_tready;
            default:            pop      = 1'b0;
        endcase
    end

    assign coef_we = pop && head.is_coef;
    assign start   = pop && !head.is_coef;

    assign base     = RES_AW'(int'(head.voice) * MODES);
    assign mode_ext = {{MODE_AW{1'b0}}, head.mode};
    assign cf_wdata = {head.mode_gain, head.pole_sin, head.pole_cos};

    assign st_we    = clr_we || v4_reg;
    assign st_waddr = clr_we ? clr_reg : a4_reg;
    assign st_wdata = clr_we ? '0 : {ny_reg, nx_reg};

    assign rx = st_rdata[mrb_pkg::STATE_W-1:0];
    assign ry = st_rdata[mrb_pkg::STATE_WORD_W-1:mrb_pkg::STATE_W];
    assign rc = cf_rdata[mrb_pkg::COEF_W-1:0];
    assign rs = cf_rdata[2*mrb_pkg::COEF_W-1:mrb_pkg::COEF_W];
    assign rg = cf_rdata[mrb_pkg::COEF_WORD_W-1:2*mrb_pkg::COEF_W];

    mrb_ram #(
        .WIDTH (mrb_pkg::STATE_WORD_W),
        .DEPTH (TOTAL)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (idx_reg),
        .rdata (st_rdata)
    );

    mrb_ram #(
        .WIDTH (mrb_pkg::COEF_WORD_W),
        .DEPTH (MODES)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (mode_ext[MODE_AW-1:0]),
        .wdata (cf_wdata),
        .raddr (m_reg),
        .rdata (cf_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrb_pkg::ST_CLEAR;
            clr_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            if (clr_we)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            voice_reg <= head.voice;
            smp_reg   <= head.excitation;
            idx_reg   <= base;
            m_reg     <= '0;
        end
        else if (issue)
        begin
            idx_reg <= idx_reg + 1'b1;
            m_reg   <= m_reg + 1'b1;
        end

        a1_reg <= idx_reg;
        a2_reg <= a1_reg;
        a3_reg <= a2_reg;
        a4_reg <= a3_reg;

        cx_reg <= rc * rx;
        sy_reg <= rs * ry;
        sx_reg <= rs * rx;
        cy_reg <= rc * ry;
        gs_reg <= rg * smp_reg;

        sumx_reg <= SUM_W'(cx_reg) - SUM_W'(sy_reg) + SUM_W'(gs_reg);
        sumy_reg <= SUM_W'(sx_reg) + SUM_W'(cy_reg);

        nx_reg <= rnd_sat(sumx_reg);
        ny_reg <= rnd_sat(sumy_reg);

        if (start)
        begin
            acc_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-mrb_pkg::STATE_W){ny_reg[mrb_pkg::STATE_W-1]}}, ny_reg};
        end

        if (load_out)
        begin
            out_voice_reg <= voice_reg;
            if (acc_reg > ACC_MAX)
            begin
                out_mix_reg <= ACC_MAX[mrb_pkg::MIX_W-1:0];
            end
            else if (acc_reg < ACC_MIN)
            begin
                out_mix_reg <= ACC_MIN[mrb_pkg::MIX_W-1:0];
            end
            else
            begin
                out_mix_reg <= acc_reg[mrb_pkg::MIX_W-1:0];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mix_reg;
    assign m_tuser  = out_voice_reg;

    a_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr_we && v4_reg))
        else $error("clearing pass collides with state write-back");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty queue");

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !pipe_busy)
        else $error("result loaded before pipeline drained");

    a_run_issues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrb_pkg::ST_RUN) |=> v1_reg)
        else $error("mode step lost in pipeline");

endmodule

/* rtl/core/modal_resonator_bank.sv */
// Excitation transactions are processed one at a time, one mode per cycle through the
// shared multiply-accumulate pipeline and the state memory; coefficient writes are applied while idle.
// Reset: asynchronous, active low; clears control, then sweeps all VOICES * MODES state memory
// entries to zero, while input transactions are still taken into the 2-entry queue.
module modal_resonator_bank #(
    parameter int VOICES = 4,
    parameter int MODES  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // voice_sel, mode_sel, excitation, pole_cos, pole_sin, mode_gain, 2 bits zero
    input  logic [mrb_pkg::TDATA_IN_W-1:0]   s_tdata,
    // cmd
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mix
    output logic [mrb_pkg::TDATA_OUT_W-1:0]  m_tdata,
    // voice_out
    output logic [mrb_pkg::TUSER_OUT_W-1:0]  m_tuser
);

    mrb_pkg::push_t  push;
    mrb_pkg::item_t  head;
    logic            q_full;
    logic            q_empty;
    logic            pop;

    mrb_front #(
        .VOICES (VOICES),
        .MODES  (MODES)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push)
    );

    mrb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .empty (q_empty),
        .head  (head)
    );

    mrb_back #(
        .VOICES (VOICES),
        .MODES  (MODES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* tb/tb.sv */
module tb;

    localparam int VOICES = 4;
    localparam int MODES  = 16;
    localparam int NRES   = VOICES * MODES;

    typedef struct {
        logic [mrb_pkg::VOICE_W-1:0] voice;
        logic [mrb_pkg::MIX_W-1:0]   mix;
    } mix_result_t;

    class mix_tracker;
        longint      res_x [NRES];
        longint      res_y [NRES];
        longint      cos_tab [MODES];
        longint      sin_tab [MODES];
        longint      gain_tab [MODES];
        mix_result_t mix_due [$];
        int          mismatches;

        function new();
            foreach (res_x[i])
            begin
                res_x[i] = 0;
                res_y[i] = 0;
            end
            foreach (cos_tab[i])
            begin
                cos_tab[i]  = 0;
                sin_tab[i]  = 0;
                gain_tab[i] = 0;
            end
            mismatches = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint round_q23(longint acc);
            return sat32((acc + 64'sd32768) >>> 16);
        endfunction

        function void take_item(mrb_pkg::item_t it);
            longint      sample;
            longint      total;
            longint      c;
            longint      s;
            longint      nx;
            longint      ny;
            int          idx;
            mix_result_t r;
            if (it.is_coef == mrb_pkg::CMD_COEF)
            begin
                cos_tab[it.mode]  = $signed(it.pole_cos);
                sin_tab[it.mode]  = $signed(it.pole_sin);
                gain_tab[it.mode] = $signed(it.mode_gain);
                return;
            end
            sample = $signed(it.excitation);
            total  = 0;
            for (int m = 0; m < MODES; m++)
            begin
                idx = int'(it.voice) * MODES + m;
                c   = cos_tab[m];
                s   = sin_tab[m];
                nx  = round_q23(c * res_x[idx] - s * res_y[idx] + gain_tab[m] * sample);
                ny  = round_q23(s * res_x[idx] + c * res_y[idx]);
                res_x[idx] = nx;
                res_y[idx] = ny;
                total += ny;
            end
            total   = sat32(total);
            r.voice = it.voice;
            r.mix   = total[mrb_pkg::MIX_W-1:0];
            mix_due.push_back(r);
        endfunction

        function void check_mix(logic [mrb_pkg::VOICE_W-1:0] voice,
                                logic [mrb_pkg::MIX_W-1:0] mix);
            mix_result_t r;
            if (mix_due.size() == 0)
            begin
                $error("unexpected result: voice_out %0d, mix %0d", voice, $signed(mix));
                mismatches++;
                return;
            end
            r = mix_due.pop_front();
            if (voice !== r.voice)
            begin
                $error("voice_out mismatch: expected %0d, actual %0d", r.voice, voice);
                mismatches++;
            end
            if (mix !== r.mix)
            begin
                $error("mix mismatch: expected %0d, actual %0d", $signed(r.mix), $signed(mix));
                mismatches++;
            end
        endfunction

        function int pending();
            return mix_due.size();
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mrb_pkg::TDATA_IN_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mrb_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic [mrb_pkg::TUSER_OUT_W-1:0] m_tuser;

    mix_tracker sb = new();

    int idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;

    modal_resonator_bank #(
        .VOICES(VOICES),
        .MODES (MODES)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        mrb_pkg::item_t it;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                it.is_coef    = s_tuser;
                it.voice      = s_tdata[mrb_pkg::VOICE_LSB +: mrb_pkg::VOICE_W];
                it.mode       = s_tdata[mrb_pkg::MODE_LSB +: mrb_pkg::MODE_W];
                it.excitation = s_tdata[mrb_pkg::EXC_LSB +: mrb_pkg::EXC_W];
                it.pole_cos   = s_tdata[mrb_pkg::COS_LSB +: mrb_pkg::COEF_W];
                it.pole_sin   = s_tdata[mrb_pkg::SIN_LSB +: mrb_pkg::COEF_W];
                it.mode_gain  = s_tdata[mrb_pkg::GAIN_LSB +: mrb_pkg::GAIN_W];
                sb.take_item(it);
            end
            if (m_tvalid && m_tready)
                sb.check_mix(m_tuser, m_tdata);
        end
    end

    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("modal_resonator_bank regression: fail");
        $finish;
    end

    task automatic send(mrb_pkg::item_t it);
        s_tvalid <= 1'b1;
        s_tuser  <= it.is_coef;
        s_tdata  <= {2'b00, it.mode_gain, it.pole_sin, it.pole_cos,
                     it.excitation, it.mode, it.voice};
        do
            @(posedge clk);
        while (!s_tready);
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic send_coef(int mode, int c, int s, int g);
        mrb_pkg::item_t it;
        it            = mrb_pkg::item_t'({$urandom, $urandom, $urandom});
        it.is_coef    = mrb_pkg::CMD_COEF;
        it.mode       = mode[mrb_pkg::MODE_W-1:0];
        it.pole_cos   = c[mrb_pkg::COEF_W-1:0];
        it.pole_sin   = s[mrb_pkg::COEF_W-1:0];
        it.mode_gain  = g[mrb_pkg::GAIN_W-1:0];
        send(it);
    endtask

    task automatic send_sample(int voice, int e);
        mrb_pkg::item_t it;
        it            = mrb_pkg::item_t'({$urandom, $urandom, $urandom});
        it.is_coef    = mrb_pkg::CMD_SAMPLE;
        it.voice      = voice[mrb_pkg::VOICE_W-1:0];
        it.excitation = e[mrb_pkg::EXC_W-1:0];
        send(it);
    endtask

    task automatic send_random();
        int e;
        if ($urandom_range(99) < 15)
        begin
            // mostly decaying poles and moderate gains, sometimes anything at all
            if ($urandom_range(99) < 80)
                send_coef($urandom_range(MODES - 1),
                          int'($urandom_range(92000)) - 46000,
                          int'($urandom_range(92000)) - 46000,
                          int'($urandom_range(131072)) - 65536);
            else
                send_coef($urandom_range(MODES - 1), $urandom, $urandom, $urandom);
        end
        else
        begin
            case ($urandom_range(9))
                0:       e = 0;
                1:       e = int'($urandom_range(2000)) - 1000;
                2:       e = ($urandom_range(1) != 0) ? 8388607 : -8388608;
                default: e = $urandom;
            endcase
            send_sample($urandom_range(VOICES - 1), e);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_coef(0, 131071, 0, 524287);
        send_coef(1, -131072, -131072, -524288);
        send_coef(2, 0, 131071, 0);
        send_coef(3, -131072, 131071, 524287);
        for (int m = 4; m < MODES; m++)
            send_coef(m, int'($urandom_range(92000)) - 46000,
                      int'($urandom_range(92000)) - 46000,
                      int'($urandom_range(131072)) - 65536);
        send_sample(0, 8388607);
        send_sample(1, -8388608);
        send_sample(2, 0);
        send_sample(3, 8388607);
        send_sample(0, -1);
        send_sample(3, 1);
        send_sample(0, -8388608);
        send_sample(0, 8388607);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct  = 32;
                    stall_pct = 32;
                end
            endcase
            for (int n = 0; n < 470; n++)
            begin
                // hold the output off so the queue fills and backs up the input
                if (ph == 0 && n == 100)
                    hold_req = 400;
                if (ph == 1 && n == 200)
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                send_random();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (MODES + 16) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("modal_resonator_bank regression: pass");
        else
            $display("modal_resonator_bank regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/mrb_pkg.sv
rtl/core/mrb_ram.sv
rtl/core/mrb_front.sv
rtl/core/mrb_queue.sv
rtl/core/mrb_back.sv
rtl/core/modal_resonator_bank.sv
tb/tb.sv
